// File: hw/rtl/b2rgb_pkg.sv
package b2rgb_pkg;

  // Default number of fraction bits of the fixed-point inputs and registers
  localparam int FRAC_BITS_DEF = 16;

  localparam int NUM_CHAN   = 3;
  localparam int IN_W       = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEGATE    = 3'd0,
    REG_RGB_MODE  = 3'd1,
    REG_USE_ICPT  = 3'd2,
    REG_LOWER     = 3'd3,
    REG_RECIP     = 3'd4,
    REG_THRESHOLD = 3'd5
  } cfg_reg_t;

endpackage

// File: hw/rtl/beta_to_rgb_pixel_mapper.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall   | in_beta_a/b/c, in_intercept (signed)
// out     | output    | out_valid/out_stall | out_chan_a/b/c, out_is_active
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// Six register stages: negate/abs, offset add and mask sum, 32x32 multiply,
// saturate/invert, square, byte scaling into the output register.
// One request per cycle while a valid output is not held by out_stall.
// rst_n is synchronous; it clears the valid bits and loads register defaults.
// A held output freezes the whole pipeline and raises in_stall in the same cycle.
module beta_to_rgb_pixel_mapper #(
  parameter int FRAC_BITS = b2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [b2rgb_pkg::IN_W-1:0]   in_beta_a,
  input  logic signed [b2rgb_pkg::IN_W-1:0]   in_beta_b,
  input  logic signed [b2rgb_pkg::IN_W-1:0]   in_beta_c,
  input  logic signed [b2rgb_pkg::IN_W-1:0]   in_intercept,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_chan_a,
  output logic [7:0]                          out_chan_b,
  output logic [7:0]                          out_chan_c,
  output logic                                out_is_active,
  input  logic                                cfg_we,
  input  logic [b2rgb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [b2rgb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int NC     = b2rgb_pkg::NUM_CHAN;
  localparam int W      = b2rgb_pkg::IN_W;
  localparam int B_W    = W + 1;               // negated beta
  localparam int D_W    = W + 2;               // beta + intercept - lower bound
  localparam int S_W    = W + 2;               // sum of three magnitudes
  localparam int PROD_W = 2 * W + 1;
  localparam int HI_W   = PROD_W - FRAC_BITS;
  localparam int NW     = FRAC_BITS + 1;       // normalized value, [0,1]
  localparam int SW     = 2 * FRAC_BITS + 1;   // squared value
  localparam int TW     = SW + 8;
  localparam logic [NW-1:0] ONE_N = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [TW-1:0] HALF  = TW'(1) << (2 * FRAC_BITS - 1);

  // Configuration registers
  logic                negate_r, rgb_r, icpt_en_r;
  logic signed [W-1:0] lower_r;
  logic [W-1:0]        recip_r, thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      negate_r  <= 1'b0;
      rgb_r     <= 1'b1;
      icpt_en_r <= 1'b0;
      lower_r   <= '0;
      recip_r   <= W'(1) << FRAC_BITS;
      thresh_r  <= W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        b2rgb_pkg::REG_NEGATE:    negate_r  <= cfg_data[0];
        b2rgb_pkg::REG_RGB_MODE:  rgb_r     <= cfg_data[0];
        b2rgb_pkg::REG_USE_ICPT:  icpt_en_r <= cfg_data[0];
        b2rgb_pkg::REG_LOWER:     lower_r   <= signed'(cfg_data[W-1:0]);
        b2rgb_pkg::REG_RECIP:     recip_r   <= cfg_data[W-1:0];
        b2rgb_pkg::REG_THRESHOLD: thresh_r  <= cfg_data[W-1:0];
        default: ;
      endcase
    end
  end

  logic advance;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  logic signed [W-1:0] in_beta [NC];
  assign in_beta[0] = in_beta_a;
  assign in_beta[1] = in_beta_b;
  assign in_beta[2] = in_beta_c;

  // Stage 1: negate and take magnitudes
  logic signed [B_W-1:0] beta1_nxt [NC];
  logic [W-1:0]          abs1_nxt  [NC];
  logic signed [B_W-1:0] beta1_r   [NC];
  logic [W-1:0]          abs1_r    [NC];
  logic signed [W-1:0]   icpt1_r;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      beta1_nxt[i] = negate_r ? -B_W'(in_beta[i]) : B_W'(in_beta[i]);
      abs1_nxt[i]  = beta1_nxt[i][B_W-1] ? W'(-beta1_nxt[i]) : W'(beta1_nxt[i]);
    end
  end

  // Stage 2: offset per channel, mask test
  logic signed [D_W-1:0] d2_nxt [NC];
  logic [S_W-1:0]        sum2;
  logic signed [D_W-1:0] d2_r   [NC];
  logic                  act2_r;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      d2_nxt[i] = D_W'(beta1_r[i]) + D_W'(icpt1_r) - D_W'(lower_r);
    end
    sum2 = S_W'(abs1_r[0]) + S_W'(abs1_r[1]) + S_W'(abs1_r[2]);
  end

  // Stage 3: multiply the low 32 bits; bit 32 is folded in next stage
  logic [W-1:0]   ud3  [NC];
  logic           top3 [NC];
  logic [2*W-1:0] mul3_r [NC];
  logic           top3_r [NC];
  logic           act3_r;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      // non-positive offsets map to zero
      if (!d2_r[i][D_W-1] && (d2_r[i] != '0)) begin
        ud3[i]  = d2_r[i][W-1:0];
        top3[i] = d2_r[i][W];
      end else begin
        ud3[i]  = '0;
        top3[i] = 1'b0;
      end
    end
  end

  // Stage 4: complete product, saturate to one, optional invert
  logic [PROD_W-1:0] prod4 [NC];
  logic [HI_W-1:0]   hi4   [NC];
  logic [NW-1:0]     n4_nxt [NC];
  logic [NW-1:0]     n4_r   [NC];
  logic              act4_r;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      prod4[i] = {1'b0, mul3_r[i]}
               + (top3_r[i] ? {1'b0, recip_r, {W{1'b0}}} : PROD_W'(0));
      hi4[i]   = prod4[i][PROD_W-1:FRAC_BITS];
      n4_nxt[i] = (hi4[i] > HI_W'(ONE_N)) ? ONE_N : hi4[i][NW-1:0];
      if (!rgb_r) begin
        n4_nxt[i] = ONE_N - n4_nxt[i];
      end
    end
  end

  // Stage 5: square
  logic [2*NW-1:0] sqf5 [NC];
  logic [SW-1:0]   sq5_r [NC];
  logic            act5_r;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      sqf5[i] = n4_r[i] * n4_r[i];
    end
  end

  // Stage 6: scale by 255, round, cap at a byte; masked voxels give zero
  logic [TW-1:0] t6   [NC];
  logic [8:0]    byte6 [NC];
  logic [7:0]    chan_nxt [NC];
  logic [7:0]    chan_r   [NC];
  logic          out_act_r;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      t6[i]    = {sq5_r[i], 8'h00} - TW'(sq5_r[i]) + HALF;
      byte6[i] = t6[i][TW-1:2*FRAC_BITS];
      if (!act5_r) begin
        chan_nxt[i] = 8'h00;
      end else if (byte6[i][8]) begin
        chan_nxt[i] = 8'hFF;
      end else begin
        chan_nxt[i] = byte6[i][7:0];
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < NC; i++) begin
        beta1_r[i] <= beta1_nxt[i];
        abs1_r[i]  <= abs1_nxt[i];
        d2_r[i]    <= d2_nxt[i];
        mul3_r[i]  <= ud3[i] * recip_r;
        top3_r[i]  <= top3[i];
        n4_r[i]    <= n4_nxt[i];
        sq5_r[i]   <= sqf5[i][SW-1:0];
        chan_r[i]  <= chan_nxt[i];
      end
      icpt1_r   <= icpt_en_r ? in_intercept : '0;
      act2_r    <= sum2 > S_W'(thresh_r);
      act3_r    <= act2_r;
      act4_r    <= act3_r;
      act5_r    <= act4_r;
      out_act_r <= act5_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_chan_a    = chan_r[0];
  assign out_chan_b    = chan_r[1];
  assign out_chan_c    = chan_r[2];
  assign out_is_active = out_act_r;

  a_masked_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_act_r) |-> (chan_r[0] == 8'h00 && chan_r[1] == 8'h00
                                     && chan_r[2] == 8'h00))
    else $error("masked voxel with nonzero channel");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (n4_r[0] <= ONE_N && n4_r[1] <= ONE_N && n4_r[2] <= ONE_N))
    else $error("normalized value above one");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && advance) |=> out_valid_r)
    else $error("request lost at output stage");

endmodule
